// File: design/stick_smooth_deadzone_map_top_macros.svh
// Assertion macros used by the stick conditioner sequencer (ssdm_ctrl).
`ifndef STICK_SMOOTH_DEADZONE_MAP_TOP_MACROS_SVH
`define STICK_SMOOTH_DEADZONE_MAP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSDM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ssdm_pkg.sv
// Package: widths, constants and shared types of the stick conditioner.
`timescale 1ns / 1ps
package ssdm_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 8;
    localparam int COND_BITS     = SAMPLE_BITS + 1;
    localparam int LEVEL_BITS    = COND_BITS + FRACTION_BITS;
    localparam int X_BITS        = LEVEL_BITS + 1 - FRACTION_BITS;
    localparam int CMP_BITS      = X_BITS + 1;
    localparam int SPAN_BITS     = SAMPLE_BITS + 2;
    localparam int DZ_BITS       = 8;
    localparam int PCT_BITS      = 7;
    localparam int OUT_BITS      = 16;
    localparam int OMAX_BITS     = 15;
    localparam int B_BITS        = OUT_BITS + 1;

    // serial multiply-accumulate and restoring divider sizes
    localparam int MUL_BITS  = X_BITS;
    localparam int CAND_BITS = LEVEL_BITS;
    localparam int ACC_BITS  = CAND_BITS + MUL_BITS + 1;
    localparam int DVD_BITS  = LEVEL_BITS + PCT_BITS + 1;
    localparam int DVS_BITS  = SAMPLE_BITS + 1;
    localparam int VAL_BITS  = DVD_BITS + 2;

    localparam int PCT_SCALE = 100;
    localparam int K_MAX     = 99;
    localparam int DIV_ROUND = PCT_SCALE / 2;
    localparam int HALF_LSB  = 1 << (FRACTION_BITS - 1);

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MIN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAW_MAX = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTRE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_MIN = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_MAX = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTH  = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] RST_RAW_MAX = SAMPLE_BITS'(4095);
    localparam logic [SAMPLE_BITS-1:0] RST_CENTRE  = SAMPLE_BITS'(2048);
    localparam logic [OUT_BITS-1:0]    RST_OUT_MIN = OUT_BITS'(-500);
    localparam logic [OMAX_BITS-1:0]   RST_OUT_MAX = OMAX_BITS'(500);
    localparam logic [PCT_BITS-1:0]    RST_SMOOTH  = PCT_BITS'(30);

    typedef struct packed {
        logic                   reverse;
        logic [SAMPLE_BITS-1:0] raw_min;
        logic [SAMPLE_BITS-1:0] raw_max;
        logic [SAMPLE_BITS-1:0] raw_centre;
        logic [DZ_BITS-1:0]     dead_zone;
        logic [OUT_BITS-1:0]    out_min;
        logic [OMAX_BITS-1:0]   out_max;
        logic [PCT_BITS-1:0]    smooth_pct;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [MUL_BITS-1:0]  mult_a;
        logic [MUL_BITS-1:0]  mult_b;
        logic [CAND_BITS-1:0] cand_a;
        logic [CAND_BITS-1:0] cand_b;
    } t_mac_cmd;

    typedef struct packed {
        logic                done;
        logic [ACC_BITS-1:0] product;
    } t_mac_rsp;

    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        logic [DVS_BITS-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic                done;
        logic [DVD_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

// File: design/ssdm_sample_if.sv
// Input channel: one raw ADC sample per request.
`timescale 1ns / 1ps
interface ssdm_sample_if;
    logic                             valid;
    logic                             ready;
    logic [ssdm_pkg::SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

// File: design/ssdm_result_if.sv
// Output channel: scaled stick value, conditioned sample and span flag.
`timescale 1ns / 1ps
interface ssdm_result_if;
    logic                           valid;
    logic                           ready;
    logic [ssdm_pkg::OUT_BITS-1:0]  stick_value;
    logic [ssdm_pkg::COND_BITS-1:0] conditioned_raw;
    logic                           span_error;

    modport source (output valid, output stick_value, output conditioned_raw,
                    output span_error, input ready);
    modport sink   (input valid, input stick_value, input conditioned_raw,
                    input span_error, output ready);
endinterface

// File: design/stick_smooth_deadzone_map_top.sv
// Top level of the stick conditioner: config registers, sequencer, serial MAC and divider.
//
//  channel    | dir | handshake             | payload
//  i_sample   | in  | valid/ready           | raw_sample[11:0]
//  o_result   | out | valid/ready           | stick_value[15:0], conditioned_raw[12:0], span_error
//  i_cfg_*    | in  | i_cfg_we, no wait     | i_cfg_idx[2:0], i_cfg_data[15:0]
//
// One request at a time. A mapped value takes two passes through the bit-serial MAC and
// the restoring divider (filter update, then linear map); inside the dead zone or on a zero
// span only the filter update pass runs.
// Synchronous active-low reset; the filter level starts at zero, registers at defaults.
// A new request is taken while a finished result waits in the output register; the last
// step holds only if that register is still occupied.
`timescale 1ns / 1ps
module stick_smooth_deadzone_map_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ssdm_sample_if.sink                         i_sample,
    ssdm_result_if.source                       o_result,
    input  logic                                i_cfg_we,
    input  logic [ssdm_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ssdm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    ssdm_pkg::t_cfg     r_cfg;
    ssdm_pkg::t_mac_cmd w_mac_cmd;
    ssdm_pkg::t_mac_rsp w_mac_rsp;
    ssdm_pkg::t_div_cmd w_div_cmd;
    ssdm_pkg::t_div_rsp w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse    <= 1'b0;
            r_cfg.raw_min    <= '0;
            r_cfg.raw_max    <= ssdm_pkg::RST_RAW_MAX;
            r_cfg.raw_centre <= ssdm_pkg::RST_CENTRE;
            r_cfg.dead_zone  <= '0;
            r_cfg.out_min    <= ssdm_pkg::RST_OUT_MIN;
            r_cfg.out_max    <= ssdm_pkg::RST_OUT_MAX;
            r_cfg.smooth_pct <= ssdm_pkg::RST_SMOOTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssdm_pkg::CFG_REVERSE: r_cfg.reverse    <= i_cfg_data[0];
                ssdm_pkg::CFG_RAW_MIN: r_cfg.raw_min    <= i_cfg_data[ssdm_pkg::SAMPLE_BITS-1:0];
                ssdm_pkg::CFG_RAW_MAX: r_cfg.raw_max    <= i_cfg_data[ssdm_pkg::SAMPLE_BITS-1:0];
                ssdm_pkg::CFG_CENTRE:  r_cfg.raw_centre <= i_cfg_data[ssdm_pkg::SAMPLE_BITS-1:0];
                ssdm_pkg::CFG_DEAD:    r_cfg.dead_zone  <= i_cfg_data[ssdm_pkg::DZ_BITS-1:0];
                ssdm_pkg::CFG_OUT_MIN: r_cfg.out_min    <= i_cfg_data[ssdm_pkg::OUT_BITS-1:0];
                ssdm_pkg::CFG_OUT_MAX: r_cfg.out_max    <= i_cfg_data[ssdm_pkg::OMAX_BITS-1:0];
                ssdm_pkg::CFG_SMOOTH:  r_cfg.smooth_pct <= i_cfg_data[ssdm_pkg::PCT_BITS-1:0];
                default: ;
            endcase
        end
    end

    ssdm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_sample  (i_sample),
        .o_result  (o_result),
        .o_mac_cmd (w_mac_cmd),
        .i_mac_rsp (w_mac_rsp),
        .o_div_cmd (w_div_cmd),
        .i_div_rsp (w_div_rsp)
    );

    ssdm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .o_rsp   (w_mac_rsp)
    );

    ssdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_rsp   (w_div_rsp)
    );
endmodule

// File: design/ssdm_mac.sv
// Bit-serial multiply-accumulate: acc = a*A + b*B, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
module ssdm_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssdm_pkg::t_mac_cmd  i_cmd,
    output ssdm_pkg::t_mac_rsp  o_rsp
);
    localparam int CNT_BITS = $clog2(ssdm_pkg::MUL_BITS + 1);
    localparam int MSB      = ssdm_pkg::MUL_BITS - 1;

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_BITS-1:0]            r_cnt;
    logic [ssdm_pkg::MUL_BITS-1:0]  r_ma;
    logic [ssdm_pkg::MUL_BITS-1:0]  r_mb;
    logic [ssdm_pkg::CAND_BITS-1:0] r_ca;
    logic [ssdm_pkg::CAND_BITS-1:0] r_cb;
    logic [ssdm_pkg::ACC_BITS-1:0]  r_acc;
    logic [ssdm_pkg::ACC_BITS-1:0]  n_acc;

    always_comb begin
        n_acc = {r_acc[ssdm_pkg::ACC_BITS-2:0], 1'b0}
              + (r_ma[MSB] ? ssdm_pkg::ACC_BITS'(r_ca) : '0)
              + (r_mb[MSB] ? ssdm_pkg::ACC_BITS'(r_cb) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(ssdm_pkg::MUL_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ma  <= i_cmd.mult_a;
            r_mb  <= i_cmd.mult_b;
            r_ca  <= i_cmd.cand_a;
            r_cb  <= i_cmd.cand_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_ma  <= {r_ma[MSB-1:0], 1'b0};
            r_mb  <= {r_mb[MSB-1:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;
endmodule

// File: design/ssdm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ssdm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssdm_pkg::t_div_cmd  i_cmd,
    output ssdm_pkg::t_div_rsp  o_rsp
);
    localparam int CNT_BITS = $clog2(ssdm_pkg::DVD_BITS + 1);
    localparam int QB       = ssdm_pkg::DVD_BITS;
    localparam int DB       = ssdm_pkg::DVS_BITS;

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [QB-1:0]       r_q;
    logic [DB-1:0]       r_rem;
    logic [DB-1:0]       r_dvs;
    logic [DB:0]         w_trial;
    logic                w_ge;
    logic [DB-1:0]       n_rem;
    logic [DB:0]         w_diff;

    always_comb begin
        w_trial = {r_rem, r_q[QB-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[DB-1:0] : w_trial[DB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(QB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q   <= i_cmd.dividend;
            r_dvs <= i_cmd.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[QB-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

// File: design/ssdm_ctrl.sv
// Sequencer: mirroring, filter update, dead-zone test, map setup, clamp and output register.
`timescale 1ns / 1ps
`include "stick_smooth_deadzone_map_top_macros.svh"
module ssdm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdm_pkg::t_cfg     i_cfg,
    ssdm_sample_if.sink        i_sample,
    ssdm_result_if.source      o_result,
    output ssdm_pkg::t_mac_cmd o_mac_cmd,
    input  ssdm_pkg::t_mac_rsp i_mac_rsp,
    output ssdm_pkg::t_div_cmd o_div_cmd,
    input  ssdm_pkg::t_div_rsp i_div_rsp
);
    localparam int CB   = ssdm_pkg::COND_BITS;
    localparam int LB   = ssdm_pkg::LEVEL_BITS;
    localparam int XB   = ssdm_pkg::X_BITS;
    localparam int WB   = ssdm_pkg::CMP_BITS;
    localparam int SB   = ssdm_pkg::SPAN_BITS;
    localparam int OB   = ssdm_pkg::OUT_BITS;
    localparam int BB   = ssdm_pkg::B_BITS;
    localparam int VB   = ssdm_pkg::VAL_BITS;
    localparam int MB   = ssdm_pkg::MUL_BITS;
    localparam int PB   = ssdm_pkg::PCT_BITS;
    localparam int FB   = ssdm_pkg::FRACTION_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MAC1  = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_EDGE  = 8'b0000_1000,
        S_MAC2  = 8'b0001_0000,
        S_DIV2  = 8'b0010_0000,
        S_CLAMP = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [LB-1:0]                  r_level;
    logic [CB-1:0]                  r_cond;
    logic                           r_neg;
    logic                           r_qsign;
    logic [ssdm_pkg::DVS_BITS-1:0]  r_span_mag;
    logic [VB-1:0]                  r_val;
    logic [OB-1:0]                  r_stick;
    logic                           r_err;
    logic                           r_ovalid;
    logic [OB-1:0]                  r_o_stick;
    logic [CB-1:0]                  r_o_cond;
    logic                           r_o_err;

    logic          w_accept;
    logic          out_free;
    logic [CB-1:0] w_samp;
    logic [CB-1:0] w_ref;
    logic [CB-1:0] w_cond;
    logic [PB-1:0] w_k;
    logic [LB:0]   w_xsum;
    logic [XB-1:0] w_x;
    logic [CB-1:0] w_hi;
    logic [SB-1:0] w_lo;
    logic          w_pos;
    logic          w_neg;
    logic [SB-1:0] w_span;
    logic [SB-1:0] w_span_abs;
    logic          w_span_zero;
    logic [WB-1:0] w_d;
    logic [WB-1:0] w_d_abs;
    logic [BB-1:0] w_nb;
    logic [BB-1:0] w_nb_abs;
    logic [MB-1:0] w_a_mag;
    logic [BB-1:0] w_b_mag;
    logic          w_psign;
    logic          w_map;
    logic [VB-1:0] w_omin_x;
    logic [VB-1:0] w_bias;
    logic [VB-1:0] w_q;
    logic [VB-1:0] w_lo_b;
    logic [VB-1:0] w_hi_b;

    assign w_accept = i_sample.valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || o_result.ready;

    always_comb begin
        // mirror about min+max with a true absolute difference
        w_samp = {1'b0, i_sample.raw_sample};
        w_ref  = {1'b0, i_cfg.raw_min} + {1'b0, i_cfg.raw_max};
        if (i_cfg.reverse) begin
            w_cond = (w_samp >= w_ref) ? w_samp - w_ref : w_ref - w_samp;
        end else begin
            w_cond = w_samp;
        end
        w_k = (i_cfg.smooth_pct > PB'(ssdm_pkg::K_MAX)) ? PB'(ssdm_pkg::K_MAX)
                                                         : i_cfg.smooth_pct;

        // rounded integer level and dead-zone edges
        w_xsum = {1'b0, r_level} + (LB + 1)'(ssdm_pkg::HALF_LSB);
        w_x    = w_xsum[LB:FB];
        w_hi   = CB'(i_cfg.raw_centre) + CB'(i_cfg.dead_zone);
        w_lo   = SB'(i_cfg.raw_centre) - SB'(i_cfg.dead_zone);
        w_pos  = w_x > XB'(w_hi);
        w_neg  = $signed({1'b0, w_x}) < $signed({w_lo[SB-1], w_lo});

        w_span      = w_pos ? SB'(i_cfg.raw_max) - SB'(w_hi)
                            : w_lo - SB'(i_cfg.raw_min);
        w_span_abs  = w_span[SB-1] ? SB'(0) - w_span : w_span;
        w_span_zero = (w_span == '0);

        // below the band: (x - raw_min) * (0 - out_min), signs kept apart
        w_d      = WB'(w_x) - WB'(i_cfg.raw_min);
        w_d_abs  = w_d[WB-1] ? WB'(0) - w_d : w_d;
        w_nb     = BB'(0) - {i_cfg.out_min[OB-1], i_cfg.out_min};
        w_nb_abs = w_nb[BB-1] ? BB'(0) - w_nb : w_nb;

        w_a_mag = w_pos ? MB'(w_x - XB'(w_hi)) : MB'(w_d_abs);
        w_b_mag = w_pos ? BB'(i_cfg.out_max) : w_nb_abs;
        w_psign = w_neg && !w_pos && (w_d[WB-1] ^ w_nb[BB-1]);
        w_map   = (w_pos || w_neg) && !w_span_zero;

        w_omin_x = {{(VB - OB){i_cfg.out_min[OB-1]}}, i_cfg.out_min};
        w_bias   = r_neg ? w_omin_x : '0;
        w_q      = VB'(i_div_rsp.quotient);
        w_lo_b   = r_neg ? w_omin_x : '0;
        w_hi_b   = r_neg ? '0 : VB'(i_cfg.out_max);
    end

    always_comb begin
        o_mac_cmd.start  = w_accept || ((r_state == S_EDGE) && w_map);
        if (r_state == S_IDLE) begin
            o_mac_cmd.mult_a = MB'(w_k);
            o_mac_cmd.mult_b = MB'(PB'(ssdm_pkg::PCT_SCALE) - w_k);
            o_mac_cmd.cand_a = r_level;
            o_mac_cmd.cand_b = {w_cond, FB'(0)};
        end else begin
            o_mac_cmd.mult_a = w_a_mag;
            o_mac_cmd.mult_b = '0;
            o_mac_cmd.cand_a = ssdm_pkg::CAND_BITS'(w_b_mag);
            o_mac_cmd.cand_b = '0;
        end

        o_div_cmd.start = i_mac_rsp.done && ((r_state == S_MAC1) || (r_state == S_MAC2));
        if (r_state == S_MAC1) begin
            o_div_cmd.dividend = ssdm_pkg::DVD_BITS'(i_mac_rsp.product)
                               + ssdm_pkg::DVD_BITS'(ssdm_pkg::DIV_ROUND);
            o_div_cmd.divisor  = ssdm_pkg::DVS_BITS'(ssdm_pkg::PCT_SCALE);
        end else begin
            o_div_cmd.dividend = ssdm_pkg::DVD_BITS'(i_mac_rsp.product);
            o_div_cmd.divisor  = r_span_mag;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MAC1;
            S_MAC1:  if (i_mac_rsp.done) n_state = S_DIV1;
            S_DIV1:  if (i_div_rsp.done) n_state = S_EDGE;
            S_EDGE:  n_state = w_map ? S_MAC2 : S_FIN;
            S_MAC2:  if (i_mac_rsp.done) n_state = S_DIV2;
            S_DIV2:  if (i_div_rsp.done) n_state = S_CLAMP;
            S_CLAMP: n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_level  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DIV1) && i_div_rsp.done) begin
                r_level <= LB'(i_div_rsp.quotient);
            end
            if ((r_state == S_FIN) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cond <= w_cond;
        end
        if (r_state == S_EDGE) begin
            r_neg      <= !w_pos;
            r_qsign    <= w_psign ^ w_span[SB-1];
            r_span_mag <= ssdm_pkg::DVS_BITS'(w_span_abs);
            r_stick    <= '0;
            r_err      <= (w_pos || w_neg) && w_span_zero;
        end
        if ((r_state == S_DIV2) && i_div_rsp.done) begin
            r_val <= r_qsign ? w_bias - w_q : w_bias + w_q;
        end
        if (r_state == S_CLAMP) begin
            // low bound wins over high bound when they cross
            if ($signed(r_val) < $signed(w_lo_b)) begin
                r_stick <= w_lo_b[OB-1:0];
            end else if ($signed(r_val) > $signed(w_hi_b)) begin
                r_stick <= w_hi_b[OB-1:0];
            end else begin
                r_stick <= r_val[OB-1:0];
            end
        end
        if ((r_state == S_FIN) && out_free) begin
            r_o_stick <= r_stick;
            r_o_cond  <= r_cond;
            r_o_err   <= r_err;
        end
    end

    assign i_sample.ready           = (r_state == S_IDLE);
    assign o_result.valid           = r_ovalid;
    assign o_result.stick_value     = r_o_stick;
    assign o_result.conditioned_raw = r_o_cond;
    assign o_result.span_error      = r_o_err;

    `SSDM_ASSERT_SAME(a_mac_done_state, i_clk, i_rst_n, i_mac_rsp.done, (r_state == S_MAC1) || (r_state == S_MAC2), "multiplier finished outside a multiply step")
    `SSDM_ASSERT_SAME(a_div_done_state, i_clk, i_rst_n, i_div_rsp.done, (r_state == S_DIV1) || (r_state == S_DIV2), "divider finished outside a divide step")
    `SSDM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_sample.valid && i_sample.ready, (r_state == S_MAC1), "accepted request did not start the filter multiply")
    `SSDM_ASSERT_NEXT(a_fin_loads, i_clk, i_rst_n, (r_state == S_FIN) && out_free, o_result.valid && (r_state == S_IDLE), "finished result not presented")
endmodule

// File: dv/ssdm_result_checker.sv
// Checker for the stick conditioner: predicts each result from the accepted samples and compares.
`timescale 1ns / 1ps
module ssdm_result_checker
    import ssdm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ssdm_sample_if                   i_sample,
    ssdm_result_if                   i_result,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending_count
);

    typedef struct {
        logic [OUT_BITS-1:0]  stick_value;
        logic [COND_BITS-1:0] conditioned_raw;
        logic                 span_error;
    } stick_result_t;

    // shadow of the register file and the filter level
    logic                    reverse;
    logic [SAMPLE_BITS-1:0]  raw_min;
    logic [SAMPLE_BITS-1:0]  raw_max;
    logic [SAMPLE_BITS-1:0]  centre;
    logic [DZ_BITS-1:0]      dead;
    logic signed [OUT_BITS-1:0] out_min;
    logic [OMAX_BITS-1:0]    out_max;
    logic [PCT_BITS-1:0]     pct;
    logic [LEVEL_BITS-1:0]   level;

    stick_result_t expected_stick_q[$];

    // Advances the filter level and returns the mapped stick result for one sample.
    function automatic stick_result_t condition_sample(input logic [SAMPLE_BITS-1:0] raw);
        stick_result_t r;
        longint mirror_pt;
        longint cond;
        longint k;
        longint num;
        longint x;
        longint hi_edge;
        longint lo_edge;
        longint span;
        longint value;
        longint omin;
        longint omax;
        logic   fault;
        cond = longint'(raw);
        if (reverse) begin
            mirror_pt = longint'(raw_min) + longint'(raw_max);
            cond = (cond >= mirror_pt) ? cond - mirror_pt : mirror_pt - cond;
        end
        k = (pct > K_MAX) ? K_MAX : longint'(pct);
        num = k * longint'(level) + (PCT_SCALE - k) * (cond << FRACTION_BITS) + DIV_ROUND;
        level = LEVEL_BITS'(num / PCT_SCALE);
        x = (longint'(level) + HALF_LSB) >> FRACTION_BITS;

        hi_edge = longint'(centre) + longint'(dead);
        lo_edge = longint'(centre) - longint'(dead);
        omin    = longint'(out_min);
        omax    = longint'(out_max);
        value   = 0;
        fault   = 1'b0;
        if (x > hi_edge) begin
            span = longint'(raw_max) - hi_edge;
            if (span == 0) begin
                fault = 1'b1;
            end else begin
                value = (x - hi_edge) * omax / span;
                if (value < 0) value = 0;
                else if (value > omax) value = omax;
            end
        end else if (x < lo_edge) begin
            span = lo_edge - longint'(raw_min);
            if (span == 0) begin
                fault = 1'b1;
            end else begin
                value = (x - longint'(raw_min)) * (0 - omin) / span + omin;
                // low bound wins when the bounds cross
                if (value < omin) value = omin;
                else if (value > 0) value = 0;
            end
        end
        if (fault) value = 0;
        r.stick_value     = value[OUT_BITS-1:0];
        r.conditioned_raw = cond[COND_BITS-1:0];
        r.span_error      = fault;
        return r;
    endfunction

    always @(posedge i_clk) begin
        stick_result_t want;
        if (!i_rst_n) begin
            reverse      = 1'b0;
            raw_min      = '0;
            raw_max      = RST_RAW_MAX;
            centre       = RST_CENTRE;
            dead         = '0;
            out_min      = RST_OUT_MIN;
            out_max      = RST_OUT_MAX;
            pct          = RST_SMOOTH;
            level        = '0;
            expected_stick_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REVERSE: reverse = i_cfg_data[0];
                    CFG_RAW_MIN: raw_min = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_RAW_MAX: raw_max = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_CENTRE:  centre  = i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_DEAD:    dead    = i_cfg_data[DZ_BITS-1:0];
                    CFG_OUT_MIN: out_min = i_cfg_data[OUT_BITS-1:0];
                    CFG_OUT_MAX: out_max = i_cfg_data[OMAX_BITS-1:0];
                    CFG_SMOOTH:  pct     = i_cfg_data[PCT_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_result.valid && i_result.ready) begin
                if (expected_stick_q.size() == 0) begin
                    $error("result with no request pending: stick_value %0d",
                           $signed(i_result.stick_value));
                    o_fail_count++;
                end else begin
                    want = expected_stick_q.pop_front();
                    if (i_result.stick_value !== want.stick_value) begin
                        $error("stick_value expected %0d actual %0d",
                               $signed(want.stick_value), $signed(i_result.stick_value));
                        o_fail_count++;
                    end
                    if (i_result.conditioned_raw !== want.conditioned_raw) begin
                        $error("conditioned_raw expected %0d actual %0d",
                               want.conditioned_raw, i_result.conditioned_raw);
                        o_fail_count++;
                    end
                    if (i_result.span_error !== want.span_error) begin
                        $error("span_error expected %0b actual %0b",
                               want.span_error, i_result.span_error);
                        o_fail_count++;
                    end
                end
            end

            if (i_sample.valid && i_sample.ready)
                expected_stick_q.push_back(condition_sample(i_sample.raw_sample));
        end
        o_pending_count = expected_stick_q.size();
    end

endmodule

// File: dv/tb.sv
// Testbench top for the stick conditioner: clock, reset, config, sample and ready stimulus.
`timescale 1ns / 1ps
module tb;
    import ssdm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 100;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 145;

    logic clk;
    logic rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int pending_count;
    int sent_count;
    int cycles;
    bit calm;
    bit hold_done;

    ssdm_sample_if sample_bus ();
    ssdm_result_if result_bus ();

    stick_smooth_deadzone_map_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_sample   (sample_bus),
        .o_result   (result_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ssdm_result_checker stick_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_sample        (sample_bus),
        .i_result        (result_bus),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offers one sample after an optional gap; returns at the falling edge after acceptance.
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] raw);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_bus.valid      <= 1'b1;
        sample_bus.raw_sample <= raw;
        @(posedge clk);
        while (!sample_bus.ready) @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_config(input t_cfg c);
        logic [CFG_DATA_BITS-1:0] regs [8];
        regs[CFG_REVERSE] = CFG_DATA_BITS'(c.reverse);
        regs[CFG_RAW_MIN] = CFG_DATA_BITS'(c.raw_min);
        regs[CFG_RAW_MAX] = CFG_DATA_BITS'(c.raw_max);
        regs[CFG_CENTRE]  = CFG_DATA_BITS'(c.raw_centre);
        regs[CFG_DEAD]    = CFG_DATA_BITS'(c.dead_zone);
        regs[CFG_OUT_MIN] = c.out_min;
        regs[CFG_OUT_MAX] = CFG_DATA_BITS'(c.out_max);
        regs[CFG_SMOOTH]  = CFG_DATA_BITS'(c.smooth_pct);
        for (int i = 0; i < 8; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_BITS'(i);
            cfg_data <= regs[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly a sane calibration around a random centre; wild settings take any field value.
    function automatic t_cfg random_config(input bit wild);
        t_cfg c;
        int   mid;
        int   dz;
        if (wild) begin
            c.reverse    = 1'($urandom);
            c.raw_min    = SAMPLE_BITS'($urandom);
            c.raw_max    = SAMPLE_BITS'($urandom);
            c.raw_centre = SAMPLE_BITS'($urandom);
            c.dead_zone  = DZ_BITS'($urandom);
            c.out_min    = OUT_BITS'($urandom);
            c.out_max    = OMAX_BITS'($urandom);
            c.smooth_pct = PCT_BITS'($urandom);
        end else begin
            mid = $urandom_range(600, 3500);
            dz  = $urandom_range(0, 255);
            c.reverse    = 1'($urandom);
            c.raw_centre = SAMPLE_BITS'(mid);
            c.dead_zone  = DZ_BITS'(dz);
            c.raw_min    = SAMPLE_BITS'($urandom_range(0, mid - dz - 1));
            c.raw_max    = SAMPLE_BITS'($urandom_range(mid + dz + 1, 4095));
            c.out_min    = OUT_BITS'(-int'($urandom_range(0, 32768)));
            c.out_max    = OMAX_BITS'($urandom_range(0, 32767));
            c.smooth_pct = PCT_BITS'($urandom_range(0, 99));
        end
        return c;
    endfunction

    // Random samples: runs that dwell on a target with small jitter, plus uniform noise.
    task automatic random_samples(input t_cfg c, input int count);
        int target;
        int s;
        target = $urandom_range(0, 4095);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0: target = $urandom_range(0, 4095);
                    1: target = 0;
                    2: target = 4095;
                    default: begin
                        target = int'(c.raw_centre) + int'(c.dead_zone) + $urandom_range(0, 40);
                        if ($urandom_range(0, 1) == 0)
                            target = 2 * int'(c.raw_centre) - target;
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 4095);
            else s = target + $urandom_range(0, 8) - 4;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
            offer_sample(SAMPLE_BITS'(s));
        end
    endtask

    // Result side: random stall bursts, one long hold-off to back up the input.
    initial begin
        result_bus.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_done && sent_count >= 200) begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("stick_smooth_deadzone_map_top verification failed");
        $finish;
    end

    initial begin
        t_cfg wide_mirror;
        t_cfg flat_span;
        t_cfg crossed;
        t_cfg top_mirror;
        t_cfg c;
        sample_bus.valid      = 1'b0;
        sample_bus.raw_sample = '0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        calm       = 1'b0;
        sent_count = 0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults
        offer_sample(12'd0);
        offer_sample(12'd4095);
        offer_sample(12'd2048);
        offer_sample(12'hAAA);
        offer_sample(12'h555);
        offer_sample(12'd1);
        wait_drained();

        // mirrored, widest output range, no smoothing, widest dead zone
        wide_mirror = '{reverse: 1'b1, raw_min: 12'd100, raw_max: 12'd3900,
                        raw_centre: 12'd2000, dead_zone: 8'd255, out_min: 16'h8000,
                        out_max: 15'd32767, smooth_pct: 7'd0};
        program_config(wide_mirror);
        offer_sample(12'd0);
        offer_sample(12'd4000);
        offer_sample(12'd4095);
        offer_sample(12'd2000);
        offer_sample(12'd1800);
        wait_drained();

        // both map spans zero
        flat_span = '{reverse: 1'b0, raw_min: 12'd1900, raw_max: 12'd2100,
                      raw_centre: 12'd2000, dead_zone: 8'd100, out_min: -16'sd1000,
                      out_max: 15'd1000, smooth_pct: 7'd0};
        program_config(flat_span);
        offer_sample(12'd4095);
        offer_sample(12'd0);
        offer_sample(12'd2000);
        offer_sample(12'd2101);
        wait_drained();

        // reversed calibration, positive low bound, smoothing above the cap
        crossed = '{reverse: 1'b0, raw_min: 12'd4000, raw_max: 12'd100,
                    raw_centre: 12'd2048, dead_zone: 8'd0, out_min: 16'd1234,
                    out_max: 15'd0, smooth_pct: 7'd127};
        program_config(crossed);
        offer_sample(12'd0);
        offer_sample(12'd4095);
        offer_sample(12'd0);
        offer_sample(12'd4095);
        wait_drained();

        // largest mirror point: conditioned sample reaches its top
        top_mirror = '{reverse: 1'b1, raw_min: 12'd4095, raw_max: 12'd4095,
                       raw_centre: 12'd0, dead_zone: 8'd255, out_min: 16'hFFFF,
                       out_max: 15'd32767, smooth_pct: 7'd99};
        program_config(top_mirror);
        offer_sample(12'd0);
        offer_sample(12'd4095);
        offer_sample(12'd0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            c = random_config(p % 3 == 2);
            if (p == RANDOM_PHASES - 1) begin
                c = random_config(1'b0);
                calm = 1'b1;
            end
            program_config(c);
            random_samples(c, PHASE_ITEMS);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("stick_smooth_deadzone_map_top verification clean");
        end else begin
            $display("stick_smooth_deadzone_map_top verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/ssdm_pkg.sv
design/ssdm_sample_if.sv
design/ssdm_result_if.sv
design/ssdm_mac.sv
design/ssdm_div.sv
design/ssdm_ctrl.sv
design/stick_smooth_deadzone_map_top.sv
dv/ssdm_result_checker.sv
dv/tb.sv
